// ===== hw/rtl/irpc_pkg.sv =====
// Package: shared types and constants of the incline relay position controller.
`timescale 1ns / 1ps
package irpc_pkg;

    localparam logic [6:0] STALL_LIMIT    = 7'd120;
    localparam logic [6:0] STALL_PERIOD   = 7'd40;
    localparam logic [7:0] STALL_MIN_MOVE = 8'd5;
    localparam logic [3:0] TURN_DWELL     = 4'd10;
    localparam logic [6:0] CAL_STABLE     = 7'd60;
    localparam logic [6:0] CAL_PAUSE      = 7'd30;
    localparam logic [7:0] CAL_MIN_SPAN   = 8'd80;
    localparam logic [7:0] WIN_TOP        = 8'd253;
    localparam logic [7:0] WIN            = 8'd2;
    localparam logic [7:0] NO_TARGET      = 8'hff;
    localparam int         DIV_BITS       = 16;

    localparam logic [2:0] REG_MAX_STEPS = 3'd0;
    localparam logic [2:0] REG_PARK      = 3'd1;
    localparam logic [2:0] REG_POLARITY  = 3'd2;
    localparam logic [2:0] REG_MIN_AD    = 3'd3;
    localparam logic [2:0] REG_MAX_AD    = 3'd4;
    localparam logic [2:0] REG_DIRECTION = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EXEC,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;      // latch the item, start the divider
        logic div_step;  // one restoring division step
        logic exec;      // apply the tick
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
    } t_status;

    function automatic logic [7:0] win_hi(input logic [7:0] v);
        return (v <= WIN_TOP) ? v + WIN : v;
    endfunction

    function automatic logic [7:0] win_lo(input logic [7:0] v);
        return (v >= WIN) ? v - WIN : v;
    endfunction

endpackage

// ===== hw/rtl/irpc_ctrl.sv =====
// Controller: sequences load, division, tick execution and result hand-off.
`timescale 1ns / 1ps
module irpc_ctrl import irpc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall,
    output logic    o_out_valid
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (i_status.div_done) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!i_out_stall) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_valid;
            end
            ST_DIV:  o_cmd.div_step = !i_status.div_done;
            ST_EXEC: o_cmd.exec = 1'b1;
            ST_OUT:  o_out_valid = 1'b1;
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

// ===== hw/rtl/irpc_datapath.sv =====
// Datapath: configuration, controller state, goal divider and tick update.
`timescale 1ns / 1ps
module irpc_datapath import irpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic [7:0]  i_sample,
    input  logic [7:0]  i_target_step,
    input  logic        i_hold_set,
    input  logic        i_hold_clear,
    input  logic        i_start_calibration,
    input  logic        i_clear_error,
    output logic        o_up_drive,
    output logic        o_down_drive,
    output logic        o_stall_error,
    output logic        o_calibration_busy,
    output logic        o_calibration_done,
    output logic        o_calibration_ok,
    output logic [7:0]  o_low_end,
    output logic [7:0]  o_high_end,
    output logic        o_sense_forward
);

    // configuration
    logic [7:0] r_max_steps, r_park, r_min_ad, r_max_ad;
    logic       r_polarity, r_direction;
    // tick state
    logic [7:0] r_last_target, r_stall_snapshot, r_cal_reference;
    logic [7:0] r_min_pos, r_max_pos, r_goal;
    logic       r_move_pending, r_heading_down, r_error, r_hold;
    logic       r_cal_active, r_fwd, r_up_on, r_down_on, r_done, r_ok;
    logic [3:0] r_turn_wait;
    logic [6:0] r_stall_ticks, r_cal_ticks;
    logic [1:0] r_cal_stage;
    // latched item
    logic [7:0] r_sample, r_step;
    logic       r_hset, r_hclr, r_cal_go, r_eclr;
    // divider: numerator span*n (16 bits) by max_steps
    logic [15:0] r_quot;
    logic [7:0]  r_rem;
    logic [4:0]  r_div_cnt;

    logic [7:0] step_c;
    logic [7:0] span_abs;
    logic [8:0] n_val;
    logic [15:0] prod;

    always_comb begin
        step_c   = (i_target_step > r_max_steps) ? r_max_steps : i_target_step;
        span_abs = (r_max_pos >= r_min_pos) ? r_max_pos - r_min_pos : r_min_pos - r_max_pos;
        n_val    = {1'b0, step_c} - 9'd1;
        if (!r_fwd) n_val = {1'b0, r_max_steps} - n_val;
        prod = {8'd0, span_abs} * {7'd0, n_val};
    end

    assign o_status.div_done = (r_div_cnt == 5'd0);

    logic [8:0] rem_sh;
    assign rem_sh = {r_rem, r_quot[15]};

    // tick update, a faithful rendering of one control tick
    logic [7:0] n_last_target, n_stall_snapshot, n_cal_reference;
    logic [7:0] n_min_pos, n_max_pos, n_goal;
    logic       n_move_pending, n_heading_down, n_error, n_hold;
    logic       n_cal_active, n_fwd, n_up_on, n_down_on, n_done, n_ok;
    logic [3:0] n_turn_wait;
    logic [6:0] n_stall_ticks, n_cal_ticks;
    logic [1:0] n_cal_stage;

    logic [7:0] goal_v, mag, c_hi, c_lo, span8, t8;
    logic       near_ref, want_up, want_down;

    always_comb begin
        n_last_target = r_last_target; n_stall_snapshot = r_stall_snapshot;
        n_cal_reference = r_cal_reference; n_min_pos = r_min_pos;
        n_max_pos = r_max_pos; n_goal = r_goal; n_move_pending = r_move_pending;
        n_heading_down = r_heading_down; n_error = r_error; n_hold = r_hold;
        n_cal_active = r_cal_active; n_fwd = r_fwd; n_up_on = r_up_on;
        n_down_on = r_down_on; n_done = 1'b0; n_ok = 1'b0;
        n_turn_wait = r_turn_wait; n_stall_ticks = r_stall_ticks;
        n_cal_ticks = r_cal_ticks; n_cal_stage = r_cal_stage;
        want_up = 1'b0; want_down = 1'b0; span8 = '0; t8 = '0;
        mag = r_quot[7:0];
        if (r_step == 8'd0) goal_v = r_park;
        else if (r_max_pos >= r_min_pos) goal_v = r_max_pos - mag;
        else goal_v = r_max_pos + mag;
        c_hi = win_hi(win_hi(r_cal_reference));
        c_lo = win_lo(win_lo(r_cal_reference));
        near_ref = (r_sample >= c_lo) && (r_sample <= c_hi);

        if (r_eclr) n_error = 1'b0;
        if (r_hclr) n_hold = 1'b0;
        if (r_hset) n_hold = 1'b1;
        if (r_cal_go) n_cal_active = 1'b1;

        if (n_error) begin
            n_up_on = 0; n_down_on = 0; n_move_pending = 0; n_turn_wait = 0;
            n_stall_ticks = 0; n_cal_active = 0; n_cal_ticks = 0; n_cal_stage = 0;
        end else if (n_cal_active) begin
            if (n_cal_ticks < 7'd127) n_cal_ticks = n_cal_ticks + 7'd1;
            case (r_cal_stage)
                2'd0: begin
                    n_up_on = 1; n_down_on = 0; n_cal_ticks = 0; n_cal_stage = 2'd1;
                end
                2'd1: begin
                    if (!near_ref) begin
                        n_cal_reference = r_sample; n_cal_ticks = 0;
                    end else if (n_cal_ticks > CAL_STABLE) begin
                        n_cal_ticks = 0; n_up_on = 0; n_min_pos = r_sample;
                        n_cal_stage = 2'd2;
                    end
                end
                2'd2: begin
                    if (n_cal_ticks >= CAL_PAUSE) begin
                        n_cal_ticks = 0; n_down_on = 1; n_cal_stage = 2'd3;
                    end
                end
                default: begin
                    if (!near_ref) begin
                        n_cal_reference = r_sample; n_cal_ticks = 0;
                    end else if (n_cal_ticks > CAL_STABLE) begin
                        n_max_pos = r_sample;
                        n_up_on = 0; n_down_on = 0; n_move_pending = 0;
                        n_turn_wait = 0; n_stall_ticks = 0; n_cal_active = 0;
                        n_cal_ticks = 0; n_cal_stage = 0;
                        n_hold = 1; n_done = 1;
                        if (n_max_pos > n_min_pos) begin
                            n_fwd = 1; span8 = n_max_pos - n_min_pos;
                        end else begin
                            n_fwd = 0; span8 = n_min_pos - n_max_pos;
                        end
                        if (span8 >= CAL_MIN_SPAN) begin
                            n_ok = 1;
                            if (n_fwd) begin
                                n_max_pos = n_max_pos - WIN; n_goal = n_max_pos;
                            end else begin
                                t8 = n_max_pos; n_max_pos = n_min_pos;
                                n_min_pos = t8 + WIN; n_goal = n_min_pos;
                            end
                        end
                    end
                end
            endcase
        end else if (n_hold) begin
            n_up_on = 0; n_down_on = 0; n_move_pending = 0; n_turn_wait = 0;
            n_stall_ticks = 0; n_cal_active = 0; n_cal_ticks = 0; n_cal_stage = 0;
            n_last_target = NO_TARGET;
        end else begin
            if (r_last_target != r_step) begin
                n_last_target = r_step; n_move_pending = 1;
            end
            if (!n_move_pending) begin
                n_up_on = 0; n_down_on = 0; n_turn_wait = 0;
                n_stall_ticks = 0; n_cal_ticks = 0; n_cal_stage = 0;
            end else begin
                n_goal = goal_v;
                if (r_sample < win_lo(goal_v)) begin
                    if (r_fwd) want_down = 1; else want_up = 1;
                end else if (r_sample > win_hi(goal_v)) begin
                    if (r_fwd) want_up = 1; else want_down = 1;
                end else begin
                    n_up_on = 0; n_down_on = 0; n_move_pending = 0; n_turn_wait = 0;
                    n_stall_ticks = 0; n_cal_ticks = 0; n_cal_stage = 0;
                end
                if (want_up || want_down) begin
                    if (want_up) n_down_on = 0; else n_up_on = 0;
                    if (r_heading_down == want_up) begin
                        // direction change: dwell with relays held
                        n_stall_ticks = 0;
                        n_turn_wait = r_turn_wait + 4'd1;
                        if (n_turn_wait >= TURN_DWELL) begin
                            n_turn_wait = 0; n_heading_down = want_down;
                        end
                    end else begin
                        if (want_up) n_up_on = 1; else n_down_on = 1;
                        if (n_stall_ticks < STALL_LIMIT) n_stall_ticks = n_stall_ticks + 7'd1;
                        if (n_stall_ticks == 7'd1) n_stall_snapshot = r_sample;
                        if (n_stall_ticks == STALL_PERIOD) begin
                            n_stall_ticks = 0;
                            t8 = (r_sample > n_stall_snapshot) ? r_sample - n_stall_snapshot
                                                               : n_stall_snapshot - r_sample;
                            if (t8 < STALL_MIN_MOVE) n_error = 1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_steps <= 8'd15; r_park <= 8'd0; r_polarity <= 1'b1;
            r_min_ad <= 8'd0; r_max_ad <= 8'd255; r_direction <= 1'b1;
            r_last_target <= NO_TARGET; r_move_pending <= 0; r_heading_down <= 0;
            r_turn_wait <= 0; r_stall_ticks <= 0; r_stall_snapshot <= 0;
            r_error <= 0; r_hold <= 0; r_cal_active <= 0; r_cal_stage <= 0;
            r_cal_ticks <= 0; r_cal_reference <= 0; r_min_pos <= 8'd0;
            r_max_pos <= 8'd255; r_fwd <= 1'b1; r_goal <= 0;
            r_up_on <= 0; r_down_on <= 0; r_done <= 0; r_ok <= 0;
            r_div_cnt <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MAX_STEPS: r_max_steps <= i_cfg_data;
                    REG_PARK:      r_park <= i_cfg_data;
                    REG_POLARITY:  r_polarity <= i_cfg_data[0];
                    REG_MIN_AD: begin
                        r_min_ad <= i_cfg_data; r_min_pos <= i_cfg_data;
                    end
                    REG_MAX_AD: begin
                        r_max_ad <= i_cfg_data; r_max_pos <= i_cfg_data;
                    end
                    REG_DIRECTION: begin
                        r_direction <= i_cfg_data[0]; r_fwd <= i_cfg_data[0];
                    end
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_sample <= i_sample; r_step <= step_c;
                r_hset <= i_hold_set; r_hclr <= i_hold_clear;
                r_cal_go <= i_start_calibration; r_eclr <= i_clear_error;
                r_quot <= prod; r_rem <= '0;
                // zero step or zero max_steps needs no division
                r_div_cnt <= (step_c == 8'd0) ? 5'd0 : 5'(DIV_BITS);
            end
            if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt - 5'd1;
                if (rem_sh >= {1'b0, r_max_steps}) begin
                    r_rem  <= 8'(rem_sh - {1'b0, r_max_steps});
                    r_quot <= {r_quot[14:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh[7:0];
                    r_quot <= {r_quot[14:0], 1'b0};
                end
            end
            if (i_cmd.exec) begin
                r_last_target <= n_last_target; r_stall_snapshot <= n_stall_snapshot;
                r_cal_reference <= n_cal_reference; r_min_pos <= n_min_pos;
                r_max_pos <= n_max_pos; r_goal <= n_goal;
                r_move_pending <= n_move_pending; r_heading_down <= n_heading_down;
                r_error <= n_error; r_hold <= n_hold; r_cal_active <= n_cal_active;
                r_fwd <= n_fwd; r_up_on <= n_up_on; r_down_on <= n_down_on;
                r_done <= n_done; r_ok <= n_ok; r_turn_wait <= n_turn_wait;
                r_stall_ticks <= n_stall_ticks; r_cal_ticks <= n_cal_ticks;
                r_cal_stage <= n_cal_stage;
            end
        end
    end

    assign o_up_drive         = r_polarity ? r_up_on : ~r_up_on;
    assign o_down_drive       = r_polarity ? r_down_on : ~r_down_on;
    assign o_stall_error      = r_error;
    assign o_calibration_busy = r_cal_active;
    assign o_calibration_done = r_done;
    assign o_calibration_ok   = r_ok;
    assign o_low_end          = r_min_pos;
    assign o_high_end         = r_max_pos;
    assign o_sense_forward    = r_fwd;

    // restore registers are shadowed into state on write; keep them observable
    logic unused_restore;
    assign unused_restore = ^{r_min_ad, r_max_ad, r_direction, r_goal, r_rem[0]};

endmodule

// ===== hw/rtl/incline_relay_position_controller.sv =====
// Top level: incline relay position controller, controller plus datapath.
// Sequence: each accepted item passes through the bit-serial goal divider
//   (16 restoring divide steps, skipped for a step-0 or clamped-to-zero item),
//   a done check, execute and output. The result register holds until taken;
//   no new item is accepted before it is handed off.
// Reset (synchronous, active low) returns configuration and all tick state
//   to their defaults; end positions and sense take the restore values.
`timescale 1ns / 1ps
module incline_relay_position_controller import irpc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write port
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    // input item channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_sample,
    input  logic [7:0] i_target_step,
    input  logic       i_hold_set,
    input  logic       i_hold_clear,
    input  logic       i_start_calibration,
    input  logic       i_clear_error,
    // result item channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_up_drive,
    output logic       o_down_drive,
    output logic       o_stall_error,
    output logic       o_calibration_busy,
    output logic       o_calibration_done,
    output logic       o_calibration_ok,
    output logic [7:0] o_low_end,
    output logic [7:0] o_high_end,
    output logic       o_sense_forward
);

    t_cmd    cmd;
    t_status status;

    // sequence each item: accept, divide, execute, present
    irpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_out_stall (i_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid)
    );

    // hold all state; results stay registered until the next item executes or a configuration write changes them
    irpc_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_sample            (i_sample),
        .i_target_step       (i_target_step),
        .i_hold_set          (i_hold_set),
        .i_hold_clear        (i_hold_clear),
        .i_start_calibration (i_start_calibration),
        .i_clear_error       (i_clear_error),
        .o_up_drive          (o_up_drive),
        .o_down_drive        (o_down_drive),
        .o_stall_error       (o_stall_error),
        .o_calibration_busy  (o_calibration_busy),
        .o_calibration_done  (o_calibration_done),
        .o_calibration_ok    (o_calibration_ok),
        .o_low_end           (o_low_end),
        .o_high_end          (o_high_end),
        .o_sense_forward     (o_sense_forward)
    );

`ifndef SYNTH
    // a new item is never taken while a result waits
    a_no_accept_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("item accepted while result pending");

    // a finished calibration never leaves the sequence running
    a_done_ends_cal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_calibration_done) |-> !o_calibration_busy)
        else $error("calibration done while still busy");

    // an ok calibration is reported only with its done pulse
    a_ok_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_calibration_ok) |-> o_calibration_done)
        else $error("calibration ok without done");
`endif

endmodule
